[rtl/core/rita_pkg.sv]
package rita_pkg;

    localparam int VALUE_BITS = 64;
    localparam int MAX_CHARS  = 64;
    localparam int MAX_DIGITS = 64;

    localparam int RADIX_W = 6;
    localparam int MIND_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int ND_W    = 7;
    localparam int POS_W   = 8;

    // divider takes eight dividend bits per cycle
    localparam int DIV_STEPS = (VALUE_BITS + 7) / 8;
    localparam int DIV_W     = DIV_STEPS * 8;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_FORCE    = 2'd2;

    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_OCT  = 2'd1;
    localparam logic [1:0] PFX_HEX  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;

    typedef enum logic [1:0] {
        SGN_NONE  = 2'd0,
        SGN_MINUS = 2'd1,
        SGN_PLUS  = 2'd2
    } sign_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] mag;
        logic [RADIX_W-1:0]    radix;
        logic [MIND_W-1:0]     min_digits;
        logic                  upper;
        logic [1:0]            n_prefix;
        sign_t                 sgn;
    } desc_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_A_UP : CH_A_LO;
        if (d < 6'd10) begin
            digit_char = CH_ZERO + {2'b00, d};
        end else begin
            digit_char = base + {2'b00, d} - 8'd10;
        end
    endfunction

endpackage

[rtl/core/rita_front.sv]
module rita_front (
    input  logic [rita_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rita_pkg::S_TUSER_W-1:0] s_tuser,
    output rita_pkg::desc_t                desc
);

    logic [rita_pkg::VALUE_BITS-1:0] v;
    logic [rita_pkg::RADIX_W-1:0]    radix_raw;
    logic [1:0]                      mode;
    logic [1:0]                      pk;
    logic                            neg;

    assign v         = s_tdata[rita_pkg::VALUE_BITS-1:0];
    assign radix_raw = s_tdata[69:64];
    assign mode      = s_tuser[1:0];
    assign pk        = s_tdata[78:77];
    assign neg       = (mode != rita_pkg::MODE_UNSIGNED) && v[rita_pkg::VALUE_BITS-1];

    always_comb begin
        // two's complement wraps the most negative value onto its unsigned magnitude
        desc.mag        = neg ? (~v + 1'b1) : v;
        desc.min_digits = s_tdata[75:70];
        desc.upper      = s_tdata[76];

        if (radix_raw < rita_pkg::RADIX_MIN) begin
            desc.radix = rita_pkg::RADIX_MIN;
        end else if (radix_raw > rita_pkg::RADIX_MAX) begin
            desc.radix = rita_pkg::RADIX_MAX;
        end else begin
            desc.radix = radix_raw;
        end

        unique case (pk)
            rita_pkg::PFX_OCT: desc.n_prefix = 2'd1;
            rita_pkg::PFX_HEX: desc.n_prefix = 2'd2;
            default:           desc.n_prefix = 2'd0;
        endcase

        if (neg) begin
            desc.sgn = rita_pkg::SGN_MINUS;
        end else if (mode == rita_pkg::MODE_UNSIGNED || mode == rita_pkg::MODE_SIGNED) begin
            desc.sgn = rita_pkg::SGN_NONE;
        end else begin
            desc.sgn = rita_pkg::SGN_PLUS;
        end
    end

endmodule

[rtl/core/rita_fifo.sv]
module rita_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rita_pkg::desc_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rita_pkg::desc_t rd_data
);

    rita_pkg::desc_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/rita_back.sv]
module rita_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           desc_valid,
    output logic                           desc_ready,
    input  rita_pkg::desc_t                desc,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rita_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [rita_pkg::DIV_W-1:0]   div_reg;
    logic [rita_pkg::DIGIT_W-1:0] rem_reg;
    logic [rita_pkg::STEP_W-1:0]  step_reg;
    logic [rita_pkg::ND_W-1:0]    nd_reg;
    logic [rita_pkg::RADIX_W-1:0] radix_reg;
    logic [rita_pkg::MIND_W-1:0]  mind_reg;
    logic                         upper_reg;
    logic [1:0]                   npre_reg;
    rita_pkg::sign_t              sgn_reg;

    logic [rita_pkg::POS_W-1:0] pre_end_reg, sign_end_reg, zero_end_reg, total_reg, cnt_reg;
    logic [rita_pkg::DIGIT_W-1:0] stack_reg [rita_pkg::MAX_DIGITS];

    logic                         m_tvalid_reg;
    logic [7:0]                   m_tdata_reg;
    logic                         m_tlast_reg;

    logic [7:0]                   qbyte;
    logic [rita_pkg::DIGIT_W-1:0] rem_next;
    logic [rita_pkg::DIV_W-1:0]   quot;
    logic                         step_last;
    logic [rita_pkg::ND_W-1:0]    nd_inc;
    logic                         more_digits;

    logic [rita_pkg::ND_W-1:0]  nz;
    logic [rita_pkg::POS_W-1:0] sign_end_c, zero_end_c, full_c;

    logic       out_free, emit_fire, emit_last, pop;
    logic [7:0] emit_char;

    assign desc_ready = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;

    // eight restoring division steps per cycle, remainder stays below the radix
    always_comb begin
        logic [6:0] r;
        logic [7:0] top;
        r     = {1'b0, rem_reg};
        top   = div_reg[rita_pkg::DIV_W-1 -: 8];
        qbyte = 8'd0;
        for (int k = 7; k >= 0; k--) begin
            r = {r[5:0], top[k]};
            if (r >= {1'b0, radix_reg}) begin
                r        = r - {1'b0, radix_reg};
                qbyte[k] = 1'b1;
            end
        end
        rem_next = r[5:0];
    end

    assign quot        = (div_reg << 8) | rita_pkg::DIV_W'(qbyte);
    assign step_last   = (step_reg == rita_pkg::STEP_W'(rita_pkg::DIV_STEPS - 1));
    assign nd_inc      = nd_reg + 1'b1;
    assign more_digits = (quot != '0) && (nd_inc < rita_pkg::ND_W'(rita_pkg::MAX_DIGITS));

    always_comb begin
        if ({1'b0, mind_reg} > nd_reg) begin
            nz = {1'b0, mind_reg} - nd_reg;
        end else begin
            nz = '0;
        end
        sign_end_c = {6'd0, npre_reg} + {7'd0, sgn_reg != rita_pkg::SGN_NONE};
        zero_end_c = sign_end_c + {1'b0, nz};
        full_c     = zero_end_c + {1'b0, nd_reg};
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign emit_last = (cnt_reg == total_reg - 1'b1);
    assign pop       = emit_fire && (cnt_reg >= zero_end_reg);

    always_comb begin
        if (cnt_reg < pre_end_reg) begin
            if (cnt_reg == '0) begin
                emit_char = rita_pkg::CH_ZERO;
            end else begin
                emit_char = upper_reg ? rita_pkg::CH_X_UP : rita_pkg::CH_X_LO;
            end
        end else if (cnt_reg < sign_end_reg) begin
            emit_char = (sgn_reg == rita_pkg::SGN_MINUS) ? rita_pkg::CH_MINUS : rita_pkg::CH_PLUS;
        end else if (cnt_reg < zero_end_reg) begin
            emit_char = rita_pkg::CH_ZERO;
        end else begin
            emit_char = rita_pkg::digit_char(stack_reg[0], upper_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (desc_valid) state_next = ST_DIV;
            ST_DIV:  if (step_last && !more_digits) state_next = ST_PREP;
            ST_PREP: state_next = ST_EMIT;
            ST_EMIT: if (emit_fire && emit_last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= emit_last;
            cnt_reg     <= cnt_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (desc_valid) begin
                    div_reg   <= rita_pkg::DIV_W'(desc.mag);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    nd_reg    <= '0;
                    radix_reg <= desc.radix;
                    mind_reg  <= desc.min_digits;
                    upper_reg <= desc.upper;
                    npre_reg  <= desc.n_prefix;
                    sgn_reg   <= desc.sgn;
                end
            end
            ST_DIV: begin
                if (step_last) begin
                    nd_reg   <= nd_inc;
                    div_reg  <= quot;
                    rem_reg  <= '0;
                    step_reg <= '0;
                end else begin
                    div_reg  <= quot;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 1'b1;
                end
            end
            ST_PREP: begin
                pre_end_reg  <= {6'd0, npre_reg};
                sign_end_reg <= sign_end_c;
                zero_end_reg <= zero_end_c;
                total_reg    <= (full_c > rita_pkg::POS_W'(rita_pkg::MAX_CHARS))
                                ? rita_pkg::POS_W'(rita_pkg::MAX_CHARS) : full_c;
                cnt_reg      <= '0;
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // digit stack: newest digit (most significant) sits at the top
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV && step_last) begin
            stack_reg[0] <= rem_next;
            for (int i = 1; i < rita_pkg::MAX_DIGITS; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < rita_pkg::MAX_DIGITS - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

endmodule

[rtl/core/radix_integer_to_ascii_unit.sv]
// Channel | Dir | tdata (lowest bit up)                            | tuser / tlast
// s_      | in  | value[63:0] radix[69:64] min_digits[75:70]       | tuser: sign_mode[1:0]
//         |     | upper_letters[76] prefix_kind[78:77] zero[79]    |
// m_      | out | char_out[7:0]                                    | tlast: last
//
// Sequence: load a request, then divide out one digit per pass of the iterative divider
// (eight dividend bits per step), size the string, then emit one character per cycle
// while the output is not stalled.
// Reset: aresetn low clears the request queue, the sequencer and the output register.
// Stalls: a two-entry request queue lets the input run ahead of the divider; the output
// register lets the next request start while the last character waits.
module radix_integer_to_ascii_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rita_pkg::S_TDATA_W-1:0] s_tdata,  // value, radix, min_digits, upper, prefix
    input  logic [rita_pkg::S_TUSER_W-1:0] s_tuser,  // sign_mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rita_pkg::M_TDATA_W-1:0] m_tdata,  // char_out
    output logic                           m_tlast
);

    rita_pkg::desc_t front_desc;
    rita_pkg::desc_t queue_desc;
    logic            queue_valid;
    logic            queue_ready;

    // classify the request: magnitude, sign, clamped radix, prefix length
    rita_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .desc    (front_desc)
    );

    // hold classified requests until the divider is free
    rita_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (front_desc),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_data  (queue_desc)
    );

    // divide out the digits, then advance through prefix, sign, zeros and digits
    rita_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (queue_valid),
        .desc_ready (queue_ready),
        .desc       (queue_desc),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[rtl/core/rita_checker.sv]
module rita_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rita_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    // a stalled character holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output character changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // reset empties the request queue
    a_reset_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // only digits, letters and sign characters come out
    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                      (m_tdata >= 8'h41 && m_tdata <= 8'h5A) ||
                      (m_tdata >= 8'h61 && m_tdata <= 8'h7A) ||
                      m_tdata == 8'h2D || m_tdata == 8'h2B))
        else $error("character outside the output set");

endmodule

bind radix_integer_to_ascii_unit rita_checker u_rita_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[test/numeral_text_checker.sv]
module numeral_text_checker
    import rita_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // value, radix, min_digits, upper_letters, prefix_kind
    input  logic [S_TUSER_W-1:0] s_tuser,  // sign_mode
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // char_out
    input  logic                 m_tlast,
    output int unsigned          mismatch_count,
    output int unsigned          pending_chars,
    output int unsigned          numbers_taken,
    output int unsigned          chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } numeral_char_t;

    numeral_char_t expected_chars[$];

    // Build the character string of one request and queue it up.
    function automatic void format_numeral(input logic [S_TDATA_W-1:0] req,
                                           input logic [S_TUSER_W-1:0] mode);
        bit [63:0]          width_mask;
        bit [63:0]          value;
        bit [63:0]          magnitude;
        bit [63:0]          rem;
        bit [RADIX_W-1:0]   radix;
        bit [MIND_W-1:0]    min_digits;
        bit                 upper;
        bit [1:0]           pfx;
        bit                 negative;
        int unsigned        base;
        bit [7:0]           digit_text[$];
        bit [7:0]           text[$];
        numeral_char_t      entry;
        width_mask = {64{1'b1}} >> (64 - VALUE_BITS);
        value      = req[63:0] & width_mask;
        radix      = req[69:64];
        min_digits = req[75:70];
        upper      = req[76];
        pfx        = req[78:77];
        negative   = (mode != MODE_UNSIGNED) && value[VALUE_BITS-1];
        // most negative value wraps to its own unsigned magnitude
        magnitude  = negative ? ((~value + 64'd1) & width_mask) : value;
        if (radix < RADIX_MIN) begin
            radix = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            radix = RADIX_MAX;
        end
        base = 32'(radix);
        do begin
            rem = magnitude % base;
            if (rem < 10) begin
                digit_text.push_front(CH_ZERO + rem[7:0]);
            end else begin
                digit_text.push_front((upper ? CH_A_UP : CH_A_LO) + rem[7:0] - 8'd10);
            end
            magnitude = magnitude / base;
        end while (magnitude != 0 && digit_text.size() < MAX_DIGITS);

        if (pfx == PFX_OCT || pfx == PFX_HEX) text.push_back(CH_ZERO);
        if (pfx == PFX_HEX) text.push_back(upper ? CH_X_UP : CH_X_LO);
        // sign mode 3 behaves like forced sign
        if (negative) begin
            text.push_back(CH_MINUS);
        end else if (mode >= MODE_FORCE) begin
            text.push_back(CH_PLUS);
        end
        for (int i = int'(min_digits) - digit_text.size(); i > 0; i--) text.push_back(CH_ZERO);
        foreach (digit_text[k]) text.push_back(digit_text[k]);
        // drop whatever runs past the output limit
        while (text.size() > MAX_CHARS) void'(text.pop_back());
        foreach (text[k]) begin
            entry.ch   = text[k];
            entry.last = (k == text.size() - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    always @(posedge aclk) begin
        numeral_char_t head;
        if (!aresetn) begin
            expected_chars.delete();
            mismatch_count <= 0;
            pending_chars  <= 0;
            numbers_taken  <= 0;
            chars_checked  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                format_numeral(s_tdata, s_tuser);
                numbers_taken <= numbers_taken + 1;
            end
            if (m_tvalid && m_tready) begin
                chars_checked <= chars_checked + 1;
                if (expected_chars.size() == 0) begin
                    $error("char_out: nothing expected, got 8'h%02h (last %0d)", m_tdata, m_tlast);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    head = expected_chars.pop_front();
                    if (m_tdata !== head.ch) begin
                        $error("char_out: expected 8'h%02h, got 8'h%02h", head.ch, m_tdata);
                        mismatch_count <= mismatch_count + 1;
                    end else if (m_tlast !== head.last) begin
                        $error("last: expected %0d, got %0d", head.last, m_tlast);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            pending_chars <= expected_chars.size();
        end
    end

endmodule

[test/tb_radix_integer_to_ascii_unit.sv]
module tb_radix_integer_to_ascii_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rita_pkg::*;

    localparam int RANDOM_NUMBERS = 445;
    localparam int BURST_NUMBERS  = 16;
    localparam int HOLD_CYCLES    = 900;
    // worst single request: load, 64 divider passes, 64 characters
    localparam int TAIL_CYCLES    = 700;
    localparam int DRAIN_LIMIT    = 200000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // tdata: value[63:0] radix[69:64] min_digits[75:70] upper_letters[76]
    //        prefix_kind[78:77] zero pad[79]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;  // tuser: sign_mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // tdata: char_out[7:0]
    logic                 m_tlast;        // tlast: last character of the number

    int unsigned mismatch_count;
    int unsigned pending_chars;
    int unsigned numbers_taken;
    int unsigned chars_checked;

    // pacing switches, shared by stimulus and receiver
    bit tx_pacing      = 1'b1;
    bit stall_receiver = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    radix_integer_to_ascii_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    numeral_text_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_chars  (pending_chars),
        .numbers_taken  (numbers_taken),
        .chars_checked  (chars_checked)
    );

    // Offer one request, after an optional idle gap, and hold it until accepted.
    task automatic send_numeral(input logic [63:0] value, input logic [1:0] sign_mode,
                                input logic [5:0] radix, input logic [5:0] min_digits,
                                input logic upper, input logic [1:0] prefix_kind);
        int gap;
        gap = tx_pacing ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {1'b0, prefix_kind, upper, min_digits, radix, value};
        s_tuser  <= sign_mode;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every queued character has come back.
    task automatic drain_chars();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_chars != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // Draw a request biased toward interesting values and common radices.
    task automatic send_random_numeral();
        logic [63:0] value;
        logic [5:0]  radix;
        logic [5:0]  min_digits;
        value = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: ;  // full-width random bits
            1: value = 64'($urandom_range(0, 1000));
            2: value = value >> $urandom_range(0, 63);
            3: value = -64'($urandom_range(1, 1000));
            4: begin
                case ($urandom_range(0, 5))
                    0: value = 64'd0;
                    1: value = 64'd1;
                    2: value = {64{1'b1}};
                    3: value = {1'b1, 63'd0};
                    4: value = {1'b0, {63{1'b1}}};
                    default: value = {1'b1, 62'd0, 1'b1};
                endcase
            end
            default: value = -(value >> $urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 9))
            6: radix = 6'd10;
            7: radix = 6'd16;
            8: radix = $urandom_range(0, 1) ? 6'd2 : 6'd8;
            // out-of-range radices clamp inside the block
            9: radix = $urandom_range(0, 1) ? 6'($urandom_range(0, 1))
                                            : 6'($urandom_range(37, 63));
            default: radix = 6'($urandom_range(2, 36));
        endcase
        min_digits = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                 : 6'($urandom_range(0, 12));
        send_numeral(value, 2'($urandom_range(0, 3)), radix, min_digits,
                     1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    endtask

    // Receiver: per character draw a stall, sometimes run flat out, and honor
    // one long hold-off request from the stimulus.
    initial begin
        int gap;
        int rx_count;
        bit rx_pacing;
        rx_count  = 0;
        rx_pacing = 1'b1;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (stall_receiver) begin
                stall_receiver = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (rx_count % 150 == 149) rx_pacing = !rx_pacing;
            gap = rx_pacing ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            rx_count++;
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero, forced sign on zero, and one digit
        send_numeral(64'd0, MODE_UNSIGNED, 6'd10, 6'd0, 1'b0, PFX_NONE);
        send_numeral(64'd0, MODE_FORCE, 6'd10, 6'd0, 1'b0, PFX_NONE);
        // widest magnitudes: all ones in base 2, extremes of the signed range
        send_numeral({64{1'b1}}, MODE_UNSIGNED, 6'd2, 6'd0, 1'b0, PFX_NONE);
        send_numeral({1'b1, 63'd0}, MODE_SIGNED, 6'd10, 6'd0, 1'b0, PFX_NONE);
        send_numeral({1'b1, 63'd0}, MODE_SIGNED, 6'd2, 6'd0, 1'b0, PFX_NONE);
        send_numeral({64{1'b1}}, MODE_SIGNED, 6'd10, 6'd0, 1'b0, PFX_NONE);
        send_numeral({1'b0, {63{1'b1}}}, MODE_FORCE, 6'd36, 6'd0, 1'b1, PFX_NONE);
        send_numeral({1'b0, {63{1'b1}}}, MODE_FORCE, 6'd36, 6'd0, 1'b0, PFX_NONE);
        // letter case and every prefix, undefined prefix included
        send_numeral(64'hDEAD_BEEF_CAFE_F00D, MODE_UNSIGNED, 6'd16, 6'd0, 1'b0, PFX_HEX);
        send_numeral(64'hDEAD_BEEF_CAFE_F00D, MODE_UNSIGNED, 6'd16, 6'd0, 1'b1, PFX_HEX);
        send_numeral(64'o1234567, MODE_UNSIGNED, 6'd8, 6'd0, 1'b0, PFX_OCT);
        send_numeral(64'd255, MODE_UNSIGNED, 6'd16, 6'd0, 1'b1, 2'd3);
        // undefined sign mode acts as forced sign
        send_numeral(64'd42, 2'd3, 6'd10, 6'd0, 1'b0, PFX_NONE);
        send_numeral(-64'd42, 2'd3, 6'd10, 6'd0, 1'b0, PFX_NONE);
        // radix below 2 and above 36 clamp
        send_numeral(64'd1000, MODE_UNSIGNED, 6'd0, 6'd0, 1'b0, PFX_NONE);
        send_numeral(64'd1000, MODE_UNSIGNED, 6'd1, 6'd0, 1'b0, PFX_NONE);
        send_numeral(64'd123456789, MODE_UNSIGNED, 6'd37, 6'd0, 1'b1, PFX_NONE);
        send_numeral(64'd123456789, MODE_UNSIGNED, 6'd63, 6'd0, 1'b0, PFX_NONE);
        // zero padding below and above the natural digit count
        send_numeral(64'd12345, MODE_SIGNED, 6'd10, 6'd3, 1'b0, PFX_NONE);
        send_numeral(-64'd7, MODE_SIGNED, 6'd10, 6'd8, 1'b0, PFX_OCT);
        // overlong strings that get cut at the character limit
        send_numeral(64'd5, MODE_FORCE, 6'd10, 6'd63, 1'b1, PFX_HEX);
        send_numeral({64{1'b1}}, MODE_UNSIGNED, 6'd2, 6'd0, 1'b0, PFX_HEX);
        send_numeral({1'b1, 63'd0}, MODE_SIGNED, 6'd2, 6'd63, 1'b1, PFX_HEX);

        // pause until every character of the directed part is back
        drain_chars();

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            if (n % 40 == 39) tx_pacing = !tx_pacing;
            if (n == 200) begin
                // hold the receiver off and keep offering back to back
                // so the request queue fills and input stalls
                stall_receiver = 1'b1;
                tx_pacing      = 1'b0;
                repeat (BURST_NUMBERS) send_random_numeral();
                tx_pacing      = 1'b1;
            end
            if (n == 320) drain_chars();
            send_random_numeral();
        end

        drain_chars();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (pending_chars != 0) $error("%0d expected characters never arrived", pending_chars);
        $display("Formatted %0d numbers (radix 0..63, all sign and prefix modes, padding, cutoff)",
                 numbers_taken);
        $display("Checked %0d characters under random stalls, a long hold-off and drain pauses",
                 chars_checked);
        if (mismatch_count == 0 && pending_chars == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #40ms;
        $display("Timeout: stimulus or results stuck");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
